>>> design/smf_pkg.sv
// Shared types, codes and helpers of the MIDI file track event parser.
`default_nettype none

package smf_pkg;

   localparam int VlvWidth   = 28;
   localparam int TickWidth  = 32;
   localparam int CountWidth = 3;

   localparam logic [2:0] KindChannel = 3'd0;
   localparam logic [2:0] KindMetaHdr = 3'd1;
   localparam logic [2:0] KindMetaPay = 3'd2;
   localparam logic [2:0] KindSysex   = 3'd3;
   localparam logic [2:0] KindError   = 3'd4;

   localparam logic [1:0] ErrNone      = 2'd0;
   localparam logic [1:0] ErrTooLong   = 2'd1;
   localparam logic [1:0] ErrNoRunning = 2'd2;
   localparam logic [1:0] ErrUnknown   = 2'd3;

   localparam logic [7:0] StatusFirst  = 8'h80;
   localparam logic [7:0] NibbleMask   = 8'h0f;
   localparam logic [7:0] HighMask     = 8'hf0;
   localparam logic [7:0] SysexStart   = 8'hf0;
   localparam logic [7:0] SysexEscape  = 8'hf7;
   localparam logic [7:0] MetaStatus   = 8'hff;
   localparam logic [7:0] ProgChange   = 8'hc0;
   localparam logic [7:0] ChanPressure = 8'hd0;
   localparam logic [7:0] MetaEndTrack = 8'h2f;

   typedef struct packed {
      logic [2:0]           kind;
      logic [7:0]           status_byte;
      logic [3:0]           chan;
      logic [6:0]           first_data;
      logic [6:0]           second_data;
      logic [7:0]           meta_kind;
      logic [VlvWidth-1:0]  meta_len;
      logic [7:0]           payload_byte;
      logic [VlvWidth-1:0]  delta_ticks;
      logic [TickWidth-1:0] abs_tick;
      logic                 track_end;
      logic [1:0]           error_code;
   } smf_result_type;

   function automatic logic meta_known(input logic [7:0] t);
      return (t <= 8'h07) || (t == 8'h20) || (t == 8'h2f) || (t == 8'h51) ||
             (t == 8'h54) || (t == 8'h58) || (t == 8'h59) || (t == 8'h7f);
   endfunction

endpackage

`default_nettype wire

>>> design/smf_if.sv
// Valid/ready channel interfaces for track bytes and parsed events.
`default_nettype none

interface smf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       track_start;

   modport source (output valid, output data_byte, output track_start, input ready);
   modport sink   (input valid, input data_byte, input track_start, output ready);
endinterface

interface smf_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  status_byte;
   logic [3:0]  chan;
   logic [6:0]  first_data;
   logic [6:0]  second_data;
   logic [7:0]  meta_kind;
   logic [27:0] meta_len;
   logic [7:0]  payload_byte;
   logic [27:0] delta_ticks;
   logic [31:0] abs_tick;
   logic        track_end;
   logic [1:0]  error_code;

   modport source (output valid, output kind, output status_byte, output chan,
                   output first_data, output second_data, output meta_kind,
                   output meta_len, output payload_byte, output delta_ticks,
                   output abs_tick, output track_end, output error_code,
                   input ready);
   modport sink   (input valid, input kind, input status_byte, input chan,
                   input first_data, input second_data, input meta_kind,
                   input meta_len, input payload_byte, input delta_ticks,
                   input abs_tick, input track_end, input error_code,
                   output ready);
endinterface

`default_nettype wire

>>> design/smf_parser.sv
// Track byte parser: state registers and per-beat next-state and event logic.
`default_nettype none

module smf_parser #(
   parameter int MAX_VLV_BYTES = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic [7:0]             data_byte,
   input  wire logic                   track_start,
   output      logic                   result_valid,
   output      smf_pkg::smf_result_type result
);
   import smf_pkg::*;

   typedef enum logic [3:0] {
      PhDelta, PhStatus, PhData1, PhData2, PhMtype,
      PhMlen, PhMdata, PhSxlen, PhSxskip
   } phase_type;

   localparam logic [CountWidth-1:0] MaxCount = CountWidth'(MAX_VLV_BYTES);

   phase_type             phase_ff, phase_in;
   logic [VlvWidth-1:0]   vlv_accum_ff, vlv_accum_in;
   logic [CountWidth-1:0] vlv_count_ff, vlv_count_in;
   logic [VlvWidth-1:0]   delta_hold_ff, delta_hold_in;
   logic [TickWidth-1:0]  tick_total_ff, tick_total_in;
   logic [7:0]            running_status_ff, running_status_in;
   logic                  running_valid_ff, running_valid_in;
   logic [7:0]            current_status_ff, current_status_in;
   logic [6:0]            held_first_ff, held_first_in;
   logic [7:0]            held_meta_ff, held_meta_in;
   logic [VlvWidth-1:0]   bytes_left_ff, bytes_left_in;

   phase_type             phase_eff;
   logic [VlvWidth-1:0]   accum_eff;
   logic [CountWidth-1:0] count_eff;
   logic [TickWidth-1:0]  tick_eff;
   logic                  run_valid_eff;
   logic [7:0]            run_status_eff;
   logic                  vlv_long;
   logic                  vlv_done;
   logic [VlvWidth-1:0]   vlv_next;
   logic [VlvWidth-1:0]   left_dec;
   logic [7:0]            hi_nibble;
   logic                  one_data;
   smf_result_type        base;

   always_comb begin
      phase_eff      = track_start ? PhDelta : phase_ff;
      accum_eff      = track_start ? '0 : vlv_accum_ff;
      count_eff      = track_start ? '0 : vlv_count_ff;
      tick_eff       = track_start ? '0 : tick_total_ff;
      run_valid_eff  = track_start ? 1'b0 : running_valid_ff;
      run_status_eff = track_start ? 8'h00 : running_status_ff;

      vlv_long  = (count_eff >= MaxCount);
      vlv_done  = !data_byte[7];
      vlv_next  = {accum_eff[VlvWidth-8:0], data_byte[6:0]};
      left_dec  = bytes_left_ff - VlvWidth'(1);
      hi_nibble = current_status_ff & HighMask;
      one_data  = (hi_nibble == ProgChange) || (hi_nibble == ChanPressure);

      phase_in          = phase_eff;
      vlv_accum_in      = accum_eff;
      vlv_count_in      = count_eff;
      delta_hold_in     = delta_hold_ff;
      tick_total_in     = tick_eff;
      running_status_in = run_status_eff;
      running_valid_in  = run_valid_eff;
      current_status_in = current_status_ff;
      held_first_in     = held_first_ff;
      held_meta_in      = held_meta_ff;
      bytes_left_in     = bytes_left_ff;

      base             = '0;
      base.delta_ticks = delta_hold_ff;
      base.abs_tick    = tick_eff;
      result_valid     = 1'b0;
      result           = base;

      unique case (phase_eff)
         PhDelta: begin
            if (vlv_long) begin
               result_valid      = 1'b1;
               result.kind       = KindError;
               result.delta_ticks = '0;
               result.error_code = ErrTooLong;
               vlv_accum_in      = '0;
               vlv_count_in      = '0;
            end else begin
               vlv_accum_in = vlv_next;
               vlv_count_in = count_eff + CountWidth'(1);
               if (vlv_done) begin
                  delta_hold_in = vlv_next;
                  tick_total_in = tick_eff + TickWidth'(vlv_next);
                  phase_in      = PhStatus;
               end
            end
         end
         PhStatus: begin
            priority if (!data_byte[7]) begin
               if (!run_valid_eff) begin
                  result_valid       = 1'b1;
                  result.kind        = KindError;
                  result.delta_ticks = '0;
                  result.error_code  = ErrNoRunning;
                  phase_in           = PhDelta;
                  vlv_accum_in       = '0;
                  vlv_count_in       = '0;
               end else begin
                  current_status_in = run_status_eff;
                  held_first_in     = data_byte[6:0];
                  if (((run_status_eff & HighMask) == ProgChange) ||
                      ((run_status_eff & HighMask) == ChanPressure)) begin
                     result_valid       = 1'b1;
                     result.kind        = KindChannel;
                     result.status_byte = run_status_eff;
                     result.chan        = run_status_eff[3:0];
                     result.first_data  = data_byte[6:0];
                     phase_in           = PhDelta;
                     vlv_accum_in       = '0;
                     vlv_count_in       = '0;
                  end else begin
                     phase_in = PhData2;
                  end
               end
            end else if (data_byte < SysexStart) begin
               current_status_in = data_byte;
               running_status_in = data_byte;
               running_valid_in  = 1'b1;
               phase_in          = PhData1;
            end else if (data_byte == MetaStatus) begin
               current_status_in = data_byte;
               phase_in          = PhMtype;
            end else if ((data_byte == SysexStart) || (data_byte == SysexEscape)) begin
               current_status_in = data_byte;
               phase_in          = PhSxlen;
               vlv_accum_in      = '0;
               vlv_count_in      = '0;
            end else begin
               phase_in     = PhDelta;
               vlv_accum_in = '0;
               vlv_count_in = '0;
            end
         end
         PhData1: begin
            held_first_in = data_byte[6:0];
            if (one_data) begin
               result_valid       = 1'b1;
               result.kind        = KindChannel;
               result.status_byte = current_status_ff;
               result.chan        = current_status_ff[3:0];
               result.first_data  = data_byte[6:0];
               phase_in           = PhDelta;
               vlv_accum_in       = '0;
               vlv_count_in       = '0;
            end else begin
               phase_in = PhData2;
            end
         end
         PhData2: begin
            result_valid       = 1'b1;
            result.kind        = KindChannel;
            result.status_byte = current_status_ff;
            result.chan        = current_status_ff[3:0];
            result.first_data  = held_first_ff;
            result.second_data = data_byte[6:0];
            phase_in           = PhDelta;
            vlv_accum_in       = '0;
            vlv_count_in       = '0;
         end
         PhMtype: begin
            held_meta_in = data_byte;
            phase_in     = PhMlen;
            vlv_accum_in = '0;
            vlv_count_in = '0;
         end
         PhMlen: begin
            if (vlv_long) begin
               result_valid       = 1'b1;
               result.kind        = KindError;
               result.delta_ticks = '0;
               result.error_code  = ErrTooLong;
               phase_in           = PhDelta;
               vlv_accum_in       = '0;
               vlv_count_in       = '0;
            end else begin
               vlv_accum_in = vlv_next;
               vlv_count_in = count_eff + CountWidth'(1);
               if (vlv_done) begin
                  bytes_left_in      = vlv_next;
                  result_valid       = 1'b1;
                  result.kind        = KindMetaHdr;
                  result.status_byte = MetaStatus;
                  result.chan        = MetaStatus[3:0];
                  result.meta_kind   = held_meta_ff;
                  result.meta_len    = vlv_next;
                  if (!meta_known(held_meta_ff)) begin
                     result.error_code = ErrUnknown;
                  end
                  if (vlv_next == '0) begin
                     result.track_end = (held_meta_ff == MetaEndTrack);
                     phase_in         = PhDelta;
                     vlv_accum_in     = '0;
                     vlv_count_in     = '0;
                  end else begin
                     phase_in = PhMdata;
                  end
               end
            end
         end
         PhMdata: begin
            result_valid        = 1'b1;
            result.kind         = KindMetaPay;
            result.status_byte  = MetaStatus;
            result.chan         = MetaStatus[3:0];
            result.meta_kind    = held_meta_ff;
            result.meta_len     = accum_eff;
            result.payload_byte = data_byte;
            bytes_left_in       = left_dec;
            if (left_dec == '0) begin
               result.track_end = (held_meta_ff == MetaEndTrack);
               phase_in         = PhDelta;
               vlv_accum_in     = '0;
               vlv_count_in     = '0;
            end
         end
         PhSxlen: begin
            if (vlv_long) begin
               result_valid       = 1'b1;
               result.kind        = KindError;
               result.delta_ticks = '0;
               result.error_code  = ErrTooLong;
               phase_in           = PhDelta;
               vlv_accum_in       = '0;
               vlv_count_in       = '0;
            end else begin
               vlv_accum_in = vlv_next;
               vlv_count_in = count_eff + CountWidth'(1);
               if (vlv_done) begin
                  bytes_left_in      = vlv_next;
                  result_valid       = 1'b1;
                  result.kind        = KindSysex;
                  result.status_byte = current_status_ff;
                  result.chan        = current_status_ff[3:0];
                  result.meta_len    = vlv_next;
                  if (vlv_next == '0) begin
                     phase_in     = PhDelta;
                     vlv_accum_in = '0;
                     vlv_count_in = '0;
                  end else begin
                     phase_in = PhSxskip;
                  end
               end
            end
         end
         PhSxskip: begin
            bytes_left_in = left_dec;
            if (left_dec == '0) begin
               phase_in     = PhDelta;
               vlv_accum_in = '0;
               vlv_count_in = '0;
            end
         end
         default: begin
            phase_in     = PhDelta;
            vlv_accum_in = '0;
            vlv_count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PhDelta;
         vlv_accum_ff      <= '0;
         vlv_count_ff      <= '0;
         delta_hold_ff     <= '0;
         tick_total_ff     <= '0;
         running_status_ff <= '0;
         running_valid_ff  <= 1'b0;
         current_status_ff <= '0;
         held_first_ff     <= '0;
         held_meta_ff      <= '0;
         bytes_left_ff     <= '0;
      end else if (advance) begin
         phase_ff          <= phase_in;
         vlv_accum_ff      <= vlv_accum_in;
         vlv_count_ff      <= vlv_count_in;
         delta_hold_ff     <= delta_hold_in;
         tick_total_ff     <= tick_total_in;
         running_status_ff <= running_status_in;
         running_valid_ff  <= running_valid_in;
         current_status_ff <= current_status_in;
         held_first_ff     <= held_first_in;
         held_meta_ff      <= held_meta_in;
         bytes_left_ff     <= bytes_left_in;
      end
   end

endmodule

`default_nettype wire

>>> design/smf_track_event_parser.sv
// Top level of the MIDI file track event parser with its event output buffer.
//
// Takes one track byte per beat, every cycle, and gives at most one event per
// byte: channel events, meta headers and meta payload bytes, sysex lengths and
// errors, each with its absolute tick and, but for errors, its delta time. An
// event is registered in the result register, or in the one skid entry while
// the sink stalls, so bytes keep flowing; the request side stops only when
// both hold an event. Delta and length quantities take up to MAX_VLV_BYTES
// bytes (1 to 4).
`default_nettype none

module smf_track_event_parser #(
   parameter int MAX_VLV_BYTES = 4
) (
   input wire logic  clock,
   input wire logic  reset,
   smf_req_if.sink   req_bus,
   smf_rsp_if.source rsp_bus
);
   import smf_pkg::*;

   logic           accept;
   logic           rsp_take;
   logic           res_valid;
   smf_result_type res;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   smf_result_type rsp_data_ff, rsp_data_in;
   smf_result_type skid_data_ff, skid_data_in;

   assign req_bus.ready = !skid_valid_ff;
   assign accept        = req_bus.valid && !skid_valid_ff;
   assign rsp_take      = rsp_valid_ff && rsp_bus.ready;

   smf_parser #(
      .MAX_VLV_BYTES(MAX_VLV_BYTES)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .data_byte    (req_bus.data_byte),
      .track_start  (req_bus.track_start),
      .result_valid (res_valid),
      .result       (res)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = accept && res_valid;
            rsp_data_in  = res;
         end
      end else if (accept && res_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.kind         = rsp_data_ff.kind;
   assign rsp_bus.status_byte  = rsp_data_ff.status_byte;
   assign rsp_bus.chan         = rsp_data_ff.chan;
   assign rsp_bus.first_data   = rsp_data_ff.first_data;
   assign rsp_bus.second_data  = rsp_data_ff.second_data;
   assign rsp_bus.meta_kind    = rsp_data_ff.meta_kind;
   assign rsp_bus.meta_len     = rsp_data_ff.meta_len;
   assign rsp_bus.payload_byte = rsp_data_ff.payload_byte;
   assign rsp_bus.delta_ticks  = rsp_data_ff.delta_ticks;
   assign rsp_bus.abs_tick     = rsp_data_ff.abs_tick;
   assign rsp_bus.track_end    = rsp_data_ff.track_end;
   assign rsp_bus.error_code   = rsp_data_ff.error_code;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench of the MIDI file track event parser: byte stream in, events checked.
module tb_top;
   import smf_pkg::*;

   localparam int VlqMaxBytes    = 4;
   localparam int RandomBytes    = 810;
   localparam int HoldCycles     = 60;
   localparam int WatchdogLimit  = 1000;
   localparam int DrainCycles    = 8;
   localparam int ReportedErrors = 10;

   localparam logic [1:0] VlqMore     = 2'd0;
   localparam logic [1:0] VlqDone     = 2'd1;
   localparam logic [1:0] VlqOverlong = 2'd2;

   localparam logic [7:0] MetaTextLast    = 8'h07;
   localparam logic [7:0] MetaChanPrefix  = 8'h20;
   localparam logic [7:0] MetaTempo       = 8'h51;
   localparam logic [7:0] MetaSmpte       = 8'h54;
   localparam logic [7:0] MetaTimeSig     = 8'h58;
   localparam logic [7:0] MetaKeySig      = 8'h59;
   localparam logic [7:0] MetaSeqSpecific = 8'h7f;
   localparam logic [7:0] MetaUnlisted    = 8'h33;
   localparam logic [7:0] SysCommonFirst  = 8'hf1;
   localparam logic [7:0] SysRealtimeLast = 8'hfe;
   localparam logic [7:0] NoteOn          = 8'h90;
   localparam logic [7:0] NoteOff         = 8'h80;
   localparam logic [7:0] PolyPressure    = 8'ha0;
   localparam logic [7:0] CtrlChange      = 8'hb0;
   localparam logic [7:0] PitchBend       = 8'he0;
   localparam logic [7:0] TimingClock     = 8'hf8;

   typedef enum logic [3:0] {
      AwaitDelta, AwaitStatus, AwaitFirst, AwaitSecond, AwaitMetaType,
      AwaitMetaLen, MetaPayload, AwaitSysexLen, SysexSkip
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] value;
      logic       start;
   } track_byte_type;

   logic clock;
   logic reset;

   smf_req_if req_bus ();
   smf_rsp_if rsp_bus ();

   smf_track_event_parser #(.MAX_VLV_BYTES(VlqMaxBytes)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   track_byte_type pending_bytes[$];
   smf_result_type expected_events[$];

   int   stim_total   = 0;
   int   bytes_in     = 0;
   int   mismatches   = 0;
   int   stall_cycles = 0;
   int   hold_left    = 0;
   int   hold_mark    = 0;
   logic hold_done    = 1'b0;
   logic byte_taken   = 1'b0;

   logic       start_pending  = 1'b0;
   logic       gen_running    = 1'b0;
   int         events_left    = 0;
   logic [7:0] run_status_gen = '0;

   // parser image
   parse_phase_type      parse_phase  = AwaitDelta;
   logic [VlvWidth-1:0]  vlq_value    = '0;
   logic [2:0]           vlq_bytes    = '0;
   logic [VlvWidth-1:0]  event_delta  = '0;
   logic [TickWidth-1:0] tick_now     = '0;
   logic [7:0]           run_status   = '0;
   logic                 run_valid    = 1'b0;
   logic [7:0]           event_status = '0;
   logic [6:0]           first_hold   = '0;
   logic [7:0]           meta_hold    = '0;
   logic [VlvWidth-1:0]  remaining    = '0;

   function automatic void vlq_clear();
      vlq_value = '0;
      vlq_bytes = '0;
   endfunction

   function automatic logic [1:0] vlq_take(input logic [7:0] b);
      if (vlq_bytes >= VlqMaxBytes) return VlqOverlong;
      vlq_value = {vlq_value[VlvWidth-8:0], b[6:0]};
      vlq_bytes = vlq_bytes + 3'd1;
      return b[7] ? VlqMore : VlqDone;
   endfunction

   function automatic logic listed_meta(input logic [7:0] t);
      return (t <= MetaTextLast) || (t == MetaChanPrefix) || (t == MetaEndTrack) ||
             (t == MetaTempo) || (t == MetaSmpte) || (t == MetaTimeSig) ||
             (t == MetaKeySig) || (t == MetaSeqSpecific);
   endfunction

   function automatic smf_result_type base_event(input logic [2:0] kind,
                                                 input logic [7:0] status);
      smf_result_type ev;
      ev             = '0;
      ev.kind        = kind;
      ev.status_byte = status;
      ev.chan        = 4'(status & NibbleMask);
      ev.delta_ticks = event_delta;
      ev.abs_tick    = tick_now;
      return ev;
   endfunction

   function automatic smf_result_type error_event(input logic [1:0] code);
      smf_result_type ev;
      ev             = base_event(KindError, '0);
      ev.delta_ticks = '0;
      ev.error_code  = code;
      parse_phase    = AwaitDelta;
      vlq_clear();
      return ev;
   endfunction

   task automatic take_first(input logic [7:0] b, output logic emitted,
                             output smf_result_type ev);
      logic [7:0] hi;
      hi         = event_status & HighMask;
      first_hold = b[6:0];
      emitted    = 1'b0;
      ev         = '0;
      if (hi == ProgChange || hi == ChanPressure) begin
         ev            = base_event(KindChannel, event_status);
         ev.first_data = first_hold;
         emitted       = 1'b1;
         parse_phase   = AwaitDelta;
         vlq_clear();
      end else begin
         parse_phase = AwaitSecond;
      end
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic start,
                             output logic emitted, output smf_result_type ev);
      logic [1:0] vs;
      emitted = 1'b0;
      ev      = '0;
      if (start) begin
         run_status  = '0;
         run_valid   = 1'b0;
         tick_now    = '0;
         parse_phase = AwaitDelta;
         vlq_clear();
      end
      case (parse_phase)
         AwaitDelta: begin
            vs = vlq_take(b);
            if (vs == VlqOverlong) begin
               ev      = error_event(ErrTooLong);
               emitted = 1'b1;
            end else if (vs == VlqDone) begin
               event_delta = vlq_value;
               tick_now    = tick_now + TickWidth'(vlq_value);
               parse_phase = AwaitStatus;
            end
         end
         AwaitStatus: begin
            if (b < StatusFirst) begin
               if (!run_valid) begin
                  ev      = error_event(ErrNoRunning);
                  emitted = 1'b1;
               end else begin
                  event_status = run_status;
                  take_first(b, emitted, ev);
               end
            end else if (b < SysexStart) begin
               event_status = b;
               run_status   = b;
               run_valid    = 1'b1;
               parse_phase  = AwaitFirst;
            end else if (b == MetaStatus) begin
               event_status = b;
               parse_phase  = AwaitMetaType;
            end else if (b == SysexStart || b == SysexEscape) begin
               event_status = b;
               parse_phase  = AwaitSysexLen;
               vlq_clear();
            end else begin
               parse_phase = AwaitDelta;
               vlq_clear();
            end
         end
         AwaitFirst: take_first(b, emitted, ev);
         AwaitSecond: begin
            ev             = base_event(KindChannel, event_status);
            ev.first_data  = first_hold;
            ev.second_data = b[6:0];
            emitted        = 1'b1;
            parse_phase    = AwaitDelta;
            vlq_clear();
         end
         AwaitMetaType: begin
            meta_hold   = b;
            parse_phase = AwaitMetaLen;
            vlq_clear();
         end
         AwaitMetaLen: begin
            vs = vlq_take(b);
            if (vs == VlqOverlong) begin
               ev      = error_event(ErrTooLong);
               emitted = 1'b1;
            end else if (vs == VlqDone) begin
               remaining    = vlq_value;
               ev           = base_event(KindMetaHdr, MetaStatus);
               ev.meta_kind = meta_hold;
               ev.meta_len  = remaining;
               if (!listed_meta(meta_hold)) ev.error_code = ErrUnknown;
               emitted = 1'b1;
               if (remaining == '0) begin
                  ev.track_end = (meta_hold == MetaEndTrack);
                  parse_phase  = AwaitDelta;
                  vlq_clear();
               end else begin
                  parse_phase = MetaPayload;
               end
            end
         end
         MetaPayload: begin
            ev              = base_event(KindMetaPay, MetaStatus);
            ev.meta_kind    = meta_hold;
            ev.meta_len     = vlq_value;
            ev.payload_byte = b;
            emitted         = 1'b1;
            remaining       = remaining - VlvWidth'(1);
            if (remaining == '0) begin
               ev.track_end = (meta_hold == MetaEndTrack);
               parse_phase  = AwaitDelta;
               vlq_clear();
            end
         end
         AwaitSysexLen: begin
            vs = vlq_take(b);
            if (vs == VlqOverlong) begin
               ev      = error_event(ErrTooLong);
               emitted = 1'b1;
            end else if (vs == VlqDone) begin
               remaining   = vlq_value;
               ev          = base_event(KindSysex, event_status);
               ev.meta_len = remaining;
               emitted     = 1'b1;
               if (remaining == '0) begin
                  parse_phase = AwaitDelta;
                  vlq_clear();
               end else begin
                  parse_phase = SysexSkip;
               end
            end
         end
         SysexSkip: begin
            remaining = remaining - VlvWidth'(1);
            if (remaining == '0) begin
               parse_phase = AwaitDelta;
               vlq_clear();
            end
         end
         default: begin
            parse_phase = AwaitDelta;
            vlq_clear();
         end
      endcase
   endtask

   // stimulus building

   task automatic put_byte(input logic [7:0] value);
      pending_bytes.push_back({value, start_pending});
      start_pending = 1'b0;
   endtask

   function automatic int vlq_len(input logic [27:0] value);
      if (value < 28'h80) return 1;
      if (value < 28'h4000) return 2;
      if (value < 28'h200000) return 3;
      return 4;
   endfunction

   task automatic put_vlq(input logic [27:0] value, input int nbytes);
      for (int i = nbytes - 1; i >= 0; i--) put_byte({i != 0, value[7*i +: 7]});
   endtask

   task automatic put_overlong();
      repeat (VlqMaxBytes) put_byte(StatusFirst | 8'($urandom_range(0, 127)));
      put_byte(8'($urandom));
   endtask

   task automatic put_delta();
      int         pick;
      int         n;
      logic [27:0] d;
      pick = $urandom_range(0, 99);
      if (pick < 30) d = '0;
      else if (pick < 60) d = 28'($urandom_range(1, 127));
      else if (pick < 70) d = 28'($urandom_range(128, 16383));
      else d = 28'($urandom_range(28'h8000000, 28'hfffffff));
      n = vlq_len(d);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(n, VlqMaxBytes);
      put_vlq(d, n);
   endtask

   function automatic logic [7:0] any_data();
      return 8'($urandom_range(0, 127)) | (($urandom_range(0, 9) == 0) ? StatusFirst : 8'h00);
   endfunction

   function automatic logic [7:0] pick_meta_type();
      case ($urandom_range(0, 11))
         0, 1:    return 8'($urandom_range(0, MetaTextLast));
         2:       return MetaChanPrefix;
         3:       return MetaEndTrack;
         4:       return MetaTempo;
         5:       return MetaSmpte;
         6:       return MetaTimeSig;
         7:       return MetaKeySig;
         8:       return MetaSeqSpecific;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic new_track();
      start_pending = 1'b1;
      gen_running   = 1'b0;
      events_left   = $urandom_range(40, 150);
      if ($urandom_range(0, 99) < 15) begin
         put_delta();
         put_byte(8'($urandom_range(0, 127)));
      end
   endtask

   task automatic gen_channel(input logic running);
      logic [7:0] status;
      logic [7:0] hi;
      if (running) begin
         status = run_status_gen;
      end else begin
         status         = {4'($urandom_range(8, 14)), 4'($urandom)};
         run_status_gen = status;
         gen_running    = 1'b1;
      end
      hi = status & HighMask;
      put_delta();
      if (!running) put_byte(status);
      put_byte(running ? 8'($urandom_range(0, 127)) : any_data());
      if (hi != ProgChange && hi != ChanPressure) put_byte(any_data());
   endtask

   task automatic gen_meta(input logic [7:0] mtype, input logic [27:0] len);
      put_delta();
      put_byte(MetaStatus);
      put_byte(mtype);
      put_vlq(len, vlq_len(len));
      repeat (len) put_byte(8'($urandom));
   endtask

   task automatic gen_sysex(input logic [27:0] len);
      put_delta();
      put_byte(($urandom_range(0, 1) == 0) ? SysexStart : SysexEscape);
      put_vlq(len, vlq_len(len));
      repeat (len) put_byte(8'($urandom));
   endtask

   function automatic int draw_meta_size();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 85) return $urandom_range(0, 6);
      if (pick < 97) return $urandom_range(7, 40);
      return $urandom_range(120, 200);
   endfunction

   task automatic build_directed();
      start_pending = 1'b1;
      put_byte(8'h00); put_byte(8'h40);
      put_vlq(0, 1); put_byte(NoteOn); put_byte(8'h00); put_byte(8'h7f);
      put_vlq(28'hfffffff, 4); put_byte(8'h7f); put_byte(8'h00);
      put_vlq(0, 4); put_byte(ProgChange | 8'h05); put_byte(8'h85);
      put_vlq(1, 1); put_byte(ChanPressure | 8'h0f); put_byte(8'hff);
      put_vlq(2, 2); put_byte(NoteOff | 8'h0a); put_byte(8'hff); put_byte(8'h80);
      put_vlq(3, 1); put_byte(PolyPressure); put_byte(8'h01); put_byte(8'h02);
      put_vlq(4, 3); put_byte(CtrlChange | 8'h03); put_byte(8'h07); put_byte(8'h64);
      put_vlq(5, 1); put_byte(PitchBend | 8'h0f); put_byte(8'h00); put_byte(8'h40);
      put_vlq(0, 1); put_byte(MetaStatus); put_byte(8'h01); put_byte(8'h03);
      put_byte(8'h41); put_byte(8'h42); put_byte(8'h43);
      put_vlq(0, 1); put_byte(8'h10); put_byte(8'h20);
      put_vlq(0, 1); put_byte(MetaStatus); put_byte(MetaUnlisted); put_byte(8'h02);
      put_byte(8'haa); put_byte(8'h55);
      put_vlq(0, 1); put_byte(MetaStatus); put_byte(MetaTempo); put_byte(8'h00);
      put_vlq(0, 1); put_byte(SysexStart); put_byte(8'h00);
      put_vlq(5, 1); put_byte(SysexEscape); put_byte(8'h03);
      put_byte(8'h01); put_byte(8'h02); put_byte(8'h03);
      put_vlq(0, 1); put_byte(SysCommonFirst);
      put_vlq(0, 1); put_byte(TimingClock);
      put_vlq(0, 1); put_byte(SysRealtimeLast);
      put_byte(8'h80); put_byte(8'h81); put_byte(8'h82); put_byte(8'h83); put_byte(8'h00);
      put_vlq(0, 1); put_byte(MetaStatus); put_byte(8'h01);
      repeat (4) put_byte(8'h80);
      put_byte(8'h05);
      put_vlq(0, 1); put_byte(SysexStart);
      repeat (4) put_byte(8'hff);
      put_byte(8'h7f);
      put_vlq(0, 1); put_byte(MetaStatus); put_byte(MetaEndTrack); put_byte(8'h02);
      put_byte(8'h00); put_byte(8'h00);
      put_vlq(0, 1); put_byte(MetaStatus); put_byte(MetaEndTrack); put_byte(8'h00);
      put_vlq(0, 1); put_byte(MetaStatus); put_byte(MetaSeqSpecific);
      put_vlq(28'hfffffff, 4); put_byte(8'h11); put_byte(8'h22); put_byte(8'h33);
      start_pending = 1'b1;
      put_vlq(0, 1); put_byte(SysexEscape);
      put_vlq(28'hfffffff, 4); put_byte(8'h01); put_byte(8'h02);
      start_pending = 1'b1;
   endtask

   task automatic build_random();
      int pick;
      int limit;
      limit = pending_bytes.size() + RandomBytes;
      new_track();
      while (pending_bytes.size() < limit) begin
         pick = $urandom_range(0, 99);
         if (pick < 30 || (pick < 48 && !gen_running)) begin
            gen_channel(1'b0);
         end else if (pick < 48) begin
            gen_channel(1'b1);
         end else if (pick < 66) begin
            gen_meta(pick_meta_type(), 28'(draw_meta_size()));
         end else if (pick < 74) begin
            gen_sysex(28'($urandom_range(0, 10)));
         end else if (pick < 78) begin
            gen_meta(MetaEndTrack, '0);
            events_left = 1;
         end else if (pick < 82) begin
            put_delta();
            put_byte(8'($urandom_range(SysCommonFirst, SysRealtimeLast)));
         end else if (pick < 86) begin
            put_overlong();
         end else if (pick < 89) begin
            put_delta();
            if ($urandom_range(0, 1) == 0) begin
               put_byte(MetaStatus);
               put_byte(pick_meta_type());
            end else begin
               put_byte(SysexStart);
            end
            put_overlong();
         end else if (pick < 93) begin
            put_delta();
            put_byte({4'($urandom_range(8, 14)), 4'($urandom)});
            if ($urandom_range(0, 1) == 0) put_byte(any_data());
            events_left = 1;
         end else begin
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
         end
         events_left--;
         if (events_left <= 0) new_track();
      end
   endtask

   // checking

   function automatic int load_phase();
      int p;
      if (stim_total == 0) return 0;
      p = bytes_in * 3 / stim_total;
      return (p > 2) ? 2 : p;
   endfunction

   function automatic logic pause_now(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= ReportedErrors) $display("%s", msg);
   endfunction

   function automatic void check_event(input smf_result_type got);
      smf_result_type want;
      string          diffs;
      if (expected_events.size() == 0) begin
         note_mismatch($sformatf("event with none pending: %p", got));
         return;
      end
      want  = expected_events.pop_front();
      diffs = "";
      if (got.kind !== want.kind) diffs = {diffs, " kind"};
      if (got.status_byte !== want.status_byte) diffs = {diffs, " status_byte"};
      if (got.chan !== want.chan) diffs = {diffs, " chan"};
      if (got.first_data !== want.first_data) diffs = {diffs, " first_data"};
      if (got.second_data !== want.second_data) diffs = {diffs, " second_data"};
      if (got.meta_kind !== want.meta_kind) diffs = {diffs, " meta_kind"};
      if (got.meta_len !== want.meta_len) diffs = {diffs, " meta_len"};
      if (got.payload_byte !== want.payload_byte) diffs = {diffs, " payload_byte"};
      if (got.delta_ticks !== want.delta_ticks) diffs = {diffs, " delta_ticks"};
      if (got.abs_tick !== want.abs_tick) diffs = {diffs, " abs_tick"};
      if (got.track_end !== want.track_end) diffs = {diffs, " track_end"};
      if (got.error_code !== want.error_code) diffs = {diffs, " error_code"};
      if (diffs != "")
         note_mismatch($sformatf("event mismatch in%s: expected %p, got %p", diffs, want, got));
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      smf_result_type got;
      smf_result_type ev;
      logic           emitted;
      byte_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.kind, rsp_bus.status_byte, rsp_bus.chan, rsp_bus.first_data,
                   rsp_bus.second_data, rsp_bus.meta_kind, rsp_bus.meta_len,
                   rsp_bus.payload_byte, rsp_bus.delta_ticks, rsp_bus.abs_tick,
                   rsp_bus.track_end, rsp_bus.error_code};
            check_event(got);
         end
         if (req_bus.valid && req_bus.ready) begin
            bytes_in <= bytes_in + 1;
            parse_byte(req_bus.data_byte, req_bus.track_start, emitted, ev);
            if (emitted) expected_events.push_back(ev);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // drive one beat per byte; hold until taken
   always @(negedge clock) begin
      track_byte_type nb;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !byte_taken) begin
      end else if (pending_bytes.size() != 0 &&
                   !pause_now(load_phase() == 0 ? 29 : load_phase() == 1 ? 83 : 0)) begin
         nb = pending_bytes.pop_front();
         req_bus.valid       <= 1'b1;
         req_bus.data_byte   <= nb.value;
         req_bus.track_start <= nb.start;
      end else begin
         req_bus.valid       <= 1'b0;
         req_bus.data_byte   <= 8'($urandom);
         req_bus.track_start <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (!hold_done && load_phase() == 2 && bytes_in >= hold_mark) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= HoldCycles - 1;
         hold_done     <= 1'b1;
      end else begin
         rsp_bus.ready <= !pause_now(load_phase() == 0 ? 83 : load_phase() == 1 ? 29 : 0);
      end
   end

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.data_byte   = '0;
      req_bus.track_start = 1'b0;
      rsp_bus.ready       = 1'b0;
      build_directed();
      build_random();
      stim_total = pending_bytes.size();
      hold_mark  = (2 * stim_total) / 3 + 30;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      while (pending_bytes.size() != 0 || req_bus.valid) @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0 && expected_events.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
